// ===== rtl/ecsm_pkg.sv =====
// Shared constants, types and field helpers for the elliptic-curve point unit.
// No dependencies; every other file depends on this package.
package ecsm_pkg;

    localparam int FIELD_BITS   = 32;
    localparam int SCALAR_BITS  = 32;
    localparam int MUL_CNT_BITS = $clog2(FIELD_BITS);
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_A = 1'd1;

    localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(5);
    localparam logic [FIELD_BITS-1:0] MODULUS_MIN   = FIELD_BITS'(3);

    typedef logic [FIELD_BITS-1:0] t_fe;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    // (u + v) mod m for u, v < m, without overflow
    function automatic t_fe f_add(input t_fe u, input t_fe v, input t_fe m);
        t_fe d;
        d = m - v;
        return (u >= d) ? (u - d) : (u + v);
    endfunction

    // (u - v) mod m for v < m
    function automatic t_fe f_sub(input t_fe u, input t_fe v, input t_fe m);
        return (u >= v) ? (u - v) : (u + (m - v));
    endfunction

endpackage

// ===== rtl/ecsm_in_if.sv =====
// Input channel: one beat carries one point operation.
// Depends on ecsm_pkg for the field and scalar widths.
interface ecsm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [ecsm_pkg::FIELD_BITS-1:0]   first_x;
    logic [ecsm_pkg::FIELD_BITS-1:0]   first_y;
    logic                              first_at_infinity;
    logic [ecsm_pkg::FIELD_BITS-1:0]   second_x;
    logic [ecsm_pkg::FIELD_BITS-1:0]   second_y;
    logic                              second_at_infinity;
    logic [ecsm_pkg::SCALAR_BITS-1:0]  scalar;

    modport source (
        output valid, kind, first_x, first_y, first_at_infinity,
               second_x, second_y, second_at_infinity, scalar,
        input  ready
    );
    modport sink (
        input  valid, kind, first_x, first_y, first_at_infinity,
               second_x, second_y, second_at_infinity, scalar,
        output ready
    );
endinterface

// ===== rtl/ecsm_out_if.sv =====
// Output channel: one beat carries one resulting point and its flag.
// Depends on ecsm_pkg for the field width.
interface ecsm_out_if;
    logic                              valid;
    logic                              ready;
    logic [ecsm_pkg::FIELD_BITS-1:0]   result_x;
    logic [ecsm_pkg::FIELD_BITS-1:0]   result_y;
    logic                              result_at_infinity;
    logic                              zero_divisor;

    modport source (
        output valid, result_x, result_y, result_at_infinity, zero_divisor,
        input  ready
    );
    modport sink (
        input  valid, result_x, result_y, result_at_infinity, zero_divisor,
        output ready
    );
endinterface

// ===== rtl/ecsm_mulmod.sv =====
// Bit-serial modular multiplier: (u * v) mod m, one bit of v per cycle, MSB first.
// Depends on ecsm_pkg; u must be below m, v may take any value.
module ecsm_mulmod (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] i_u,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] i_v,
    input  logic [ecsm_pkg::FIELD_BITS-1:0] i_m,
    output ecsm_pkg::t_mul_stat             o_stat,
    output logic [ecsm_pkg::FIELD_BITS-1:0] o_res
);
    import ecsm_pkg::*;

    localparam logic [MUL_CNT_BITS-1:0] CNT_LAST = MUL_CNT_BITS'(FIELD_BITS - 1);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [MUL_CNT_BITS-1:0] r_cnt, n_cnt;
    t_fe                     r_acc, n_acc;
    t_fe                     r_u, n_u;
    t_fe                     r_v, n_v;
    t_fe                     dbl;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_u    = r_u;
        n_v    = r_v;
        dbl    = f_add(r_acc, r_acc, i_m);
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_u    = i_u;
            n_v    = i_v;
        end else if (r_busy) begin
            n_acc = r_v[FIELD_BITS-1] ? f_add(dbl, r_u, i_m) : dbl;
            n_v   = r_v << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_u   <= n_u;
        r_v   <= n_v;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_acc;

endmodule

// ===== rtl/ec_point_scalar_multiply.sv =====
// Elliptic-curve point unit over a prime field, affine coordinates.
// Channels: i_item (sink) takes one operation per beat: kind 0 adds the first
// and second point, kind 1 multiplies the first point by the scalar with LSB-first
// double-and-add. o_result (source) returns exactly one point per operation,
// with zero_divisor raised when an inversion of zero was hit (off-curve input).
// Configuration: i_cfg_we writes modulus (index 0) or curve_a (index 1); write
// only while no operation is in flight.
// Cost: all field products go through one bit-serial multiplier. Input reduction
// costs 5 products. One point addition costs up to 4 + 2*bitlen(p-2) products,
// the inversion x^(p-2) dominating. A kind 1 beat runs up to 2*SCALAR_BITS-1
// additions; a kind 0 beat runs one.
// Throughput: one operation at a time; i_item.ready is high only while idle.
// A finished result sits in the output register; if the receiver stalls, the
// next operation may still be accepted and runs until its own result is due,
// then holds until the previous beat is taken.
// Reset (synchronous, active low): modulus returns to 5, curve_a to 0, the
// sequencer to idle and the output register empties.
module ec_point_scalar_multiply (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ecsm_in_if.sink                           i_item,
    ecsm_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [ecsm_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [ecsm_pkg::FIELD_BITS-1:0]   i_cfg_data
);
    import ecsm_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_RED      = 22'h000002,
        S_SETUP    = 22'h000004,
        S_SM_TOP   = 22'h000008,
        S_SM_SHIFT = 22'h000010,
        S_ADD_CHK  = 22'h000020,
        S_DBL_SQ   = 22'h000040,
        S_DBL_T2   = 22'h000080,
        S_DBL_T3   = 22'h000100,
        S_DBL_NUM  = 22'h000200,
        S_DEN_CHK  = 22'h000400,
        S_INV_MUL  = 22'h000800,
        S_INV_SQ   = 22'h001000,
        S_LAM      = 22'h002000,
        S_LSQ      = 22'h004000,
        S_X3A      = 22'h008000,
        S_X3B      = 22'h010000,
        S_YD       = 22'h020000,
        S_YM       = 22'h040000,
        S_YS       = 22'h080000,
        S_ADD_DONE = 22'h100000,
        S_FIN      = 22'h200000
    } t_state;

    // where the result of the shared point addition goes
    typedef enum logic [1:0] {
        PH_PAIR = 2'd0,
        PH_ACC  = 2'd1,
        PH_DBL  = 2'd2
    } t_phase;

    localparam logic [2:0] RED_A    = 3'd0;
    localparam logic [2:0] RED_X1   = 3'd1;
    localparam logic [2:0] RED_Y1   = 3'd2;
    localparam logic [2:0] RED_X2   = 3'd3;
    localparam logic [2:0] RED_LAST = 3'd4;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_pend, n_pend;
    logic [2:0] r_cnt, n_cnt;
    logic   r_kind, n_kind;
    logic [SCALAR_BITS-1:0] r_k, n_k;
    logic   r_flag, n_flag;

    t_fe  r_modulus, r_curve_a;
    t_fe  m_eff;

    // operands, reduced in place
    t_fe  r_a, n_a, r_x1, n_x1, r_y1, n_y1, r_x2, n_x2, r_y2, n_y2;
    logic r_inf1, n_inf1, r_inf2, n_inf2;
    // addition inputs A, B; accumulator C; base D; addition result R
    t_fe  r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;
    t_fe  r_cx, n_cx, r_cy, n_cy, r_dx, n_dx, r_dy, n_dy;
    t_fe  r_rx, n_rx, r_ry, n_ry;
    logic r_ainf, n_ainf, r_binf, n_binf, r_cinf, n_cinf;
    logic r_dinf, n_dinf, r_rinf, n_rinf;
    // addition working values
    t_fe  r_num, n_num, r_den, n_den, r_inv, n_inv, r_pow, n_pow, r_e, n_e;
    t_fe  r_lam, n_lam, r_t, n_t, r_tmp, n_tmp, r_x3, n_x3;
    // output register
    logic r_ovalid, n_ovalid;
    t_fe  r_ox, n_ox, r_oy, n_oy;
    logic r_oinf, n_oinf, r_oflag, n_oflag;

    logic      mul_req, mul_start;
    t_fe       mul_u, mul_v, mul_res, red_src, neg_by;
    t_mul_stat mul_stat;

    assign m_eff = (r_modulus < MODULUS_MIN) ? MODULUS_MIN : r_modulus;

    always_comb begin
        case (r_cnt)
            RED_A:   red_src = r_a;
            RED_X1:  red_src = r_x1;
            RED_Y1:  red_src = r_y1;
            RED_X2:  red_src = r_x2;
            default: red_src = r_y2;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_req = 1'b0;
        mul_u   = '0;
        mul_v   = '0;
        case (r_state)
            S_RED: begin
                mul_req = 1'b1;
                mul_u   = FIELD_BITS'(1);
                mul_v   = red_src;
            end
            S_DBL_SQ: begin
                mul_req = 1'b1;
                mul_u   = r_ax;
                mul_v   = r_ax;
            end
            S_INV_MUL: begin
                mul_req = (r_e != '0) && r_e[0];
                mul_u   = r_inv;
                mul_v   = r_pow;
            end
            S_INV_SQ: begin
                mul_req = 1'b1;
                mul_u   = r_pow;
                mul_v   = r_pow;
            end
            S_LAM: begin
                mul_req = 1'b1;
                mul_u   = r_num;
                mul_v   = r_inv;
            end
            S_LSQ: begin
                mul_req = 1'b1;
                mul_u   = r_lam;
                mul_v   = r_lam;
            end
            S_YM: begin
                mul_req = 1'b1;
                mul_u   = r_lam;
                mul_v   = r_tmp;
            end
            default: mul_req = 1'b0;
        endcase
    end

    assign mul_start = mul_req && !r_pend;

    ecsm_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_u     (mul_u),
        .i_v     (mul_v),
        .i_m     (m_eff),
        .o_stat  (mul_stat),
        .o_res   (mul_res)
    );

    assign neg_by = f_sub('0, r_by, m_eff);

    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_cnt = r_cnt;
        n_kind  = r_kind;   n_k = r_k;          n_flag = r_flag;
        n_a  = r_a;   n_x1 = r_x1;  n_y1 = r_y1;  n_x2 = r_x2;  n_y2 = r_y2;
        n_inf1 = r_inf1;  n_inf2 = r_inf2;
        n_ax = r_ax;  n_ay = r_ay;  n_ainf = r_ainf;
        n_bx = r_bx;  n_by = r_by;  n_binf = r_binf;
        n_cx = r_cx;  n_cy = r_cy;  n_cinf = r_cinf;
        n_dx = r_dx;  n_dy = r_dy;  n_dinf = r_dinf;
        n_rx = r_rx;  n_ry = r_ry;  n_rinf = r_rinf;
        n_num = r_num;  n_den = r_den;  n_inv = r_inv;  n_pow = r_pow;
        n_e = r_e;  n_lam = r_lam;  n_t = r_t;  n_tmp = r_tmp;  n_x3 = r_x3;
        n_ox = r_ox;  n_oy = r_oy;  n_oinf = r_oinf;  n_oflag = r_oflag;
        n_ovalid = r_ovalid;

        // track the outstanding product
        n_pend = r_pend;
        if (mul_start) begin
            n_pend = 1'b1;
        end else if (mul_stat.done) begin
            n_pend = 1'b0;
        end

        // drop the output beat once taken
        if (r_ovalid && o_result.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_kind  = i_item.kind;
                    n_x1    = i_item.first_x;
                    n_y1    = i_item.first_y;
                    n_inf1  = i_item.first_at_infinity;
                    n_x2    = i_item.second_x;
                    n_y2    = i_item.second_y;
                    n_inf2  = i_item.second_at_infinity;
                    n_k     = i_item.scalar;
                    n_a     = r_curve_a;
                    n_flag  = 1'b0;
                    n_cnt   = RED_A;
                    n_state = S_RED;
                end
            end
            // reduce curve_a and the coordinates as 1 * value mod m
            S_RED: begin
                if (mul_stat.done) begin
                    case (r_cnt)
                        RED_A:   n_a  = mul_res;
                        RED_X1:  n_x1 = mul_res;
                        RED_Y1:  n_y1 = mul_res;
                        RED_X2:  n_x2 = mul_res;
                        default: n_y2 = mul_res;
                    endcase
                    if (r_cnt == RED_LAST) begin
                        n_state = S_SETUP;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            S_SETUP: begin
                if (!r_kind) begin
                    n_ax    = r_inf1 ? '0 : r_x1;
                    n_ay    = r_inf1 ? '0 : r_y1;
                    n_ainf  = r_inf1;
                    n_bx    = r_inf2 ? '0 : r_x2;
                    n_by    = r_inf2 ? '0 : r_y2;
                    n_binf  = r_inf2;
                    n_phase = PH_PAIR;
                    n_state = S_ADD_CHK;
                end else begin
                    n_cx    = '0;
                    n_cy    = '0;
                    n_cinf  = 1'b1;
                    n_dx    = r_inf1 ? '0 : r_x1;
                    n_dy    = r_inf1 ? '0 : r_y1;
                    n_dinf  = r_inf1;
                    n_state = S_SM_TOP;
                end
            end
            S_SM_TOP: begin
                if (r_k == '0) begin
                    n_rx    = r_cx;
                    n_ry    = r_cy;
                    n_rinf  = r_cinf;
                    n_state = S_FIN;
                end else if (r_k[0]) begin
                    n_ax = r_cx;  n_ay = r_cy;  n_ainf = r_cinf;
                    n_bx = r_dx;  n_by = r_dy;  n_binf = r_dinf;
                    n_phase = PH_ACC;
                    n_state = S_ADD_CHK;
                end else begin
                    n_state = S_SM_SHIFT;
                end
            end
            S_SM_SHIFT: begin
                n_k = r_k >> 1;
                if ((r_k >> 1) != '0) begin
                    n_ax = r_dx;  n_ay = r_dy;  n_ainf = r_dinf;
                    n_bx = r_dx;  n_by = r_dy;  n_binf = r_dinf;
                    n_phase = PH_DBL;
                    n_state = S_ADD_CHK;
                end else begin
                    n_state = S_SM_TOP;
                end
            end
            S_ADD_CHK: begin
                if (r_ainf) begin
                    n_rx = r_bx;  n_ry = r_by;  n_rinf = r_binf;
                    n_state = S_ADD_DONE;
                end else if (r_binf) begin
                    n_rx = r_ax;  n_ry = r_ay;  n_rinf = 1'b0;
                    n_state = S_ADD_DONE;
                end else if (r_ax == r_bx && r_ay == neg_by) begin
                    n_rx = '0;  n_ry = '0;  n_rinf = 1'b1;
                    n_state = S_ADD_DONE;
                end else if (r_ax == r_bx && r_ay == r_by) begin
                    n_state = S_DBL_SQ;
                end else begin
                    n_num   = f_sub(r_by, r_ay, m_eff);
                    n_den   = f_sub(r_bx, r_ax, m_eff);
                    n_state = S_DEN_CHK;
                end
            end
            S_DBL_SQ: begin
                if (mul_stat.done) begin
                    n_t     = mul_res;
                    n_state = S_DBL_T2;
                end
            end
            S_DBL_T2: begin
                n_tmp   = f_add(r_t, r_t, m_eff);
                n_state = S_DBL_T3;
            end
            S_DBL_T3: begin
                n_tmp   = f_add(r_tmp, r_t, m_eff);
                n_state = S_DBL_NUM;
            end
            S_DBL_NUM: begin
                n_num   = f_add(r_tmp, r_a, m_eff);
                n_den   = f_add(r_ay, r_ay, m_eff);
                n_state = S_DEN_CHK;
            end
            S_DEN_CHK: begin
                if (r_den == '0) begin
                    n_flag = 1'b1;
                    n_rx = '0;  n_ry = '0;  n_rinf = 1'b1;
                    n_state = S_ADD_DONE;
                end else begin
                    n_inv   = FIELD_BITS'(1);
                    n_pow   = r_den;
                    n_e     = m_eff - FIELD_BITS'(2);
                    n_state = S_INV_MUL;
                end
            end
            // square-and-multiply for den^(m-2)
            S_INV_MUL: begin
                if (r_e == '0) begin
                    n_state = S_LAM;
                end else if (!r_e[0]) begin
                    n_state = S_INV_SQ;
                end else if (mul_stat.done) begin
                    n_inv   = mul_res;
                    n_state = S_INV_SQ;
                end
            end
            S_INV_SQ: begin
                if (mul_stat.done) begin
                    n_pow   = mul_res;
                    n_e     = r_e >> 1;
                    n_state = S_INV_MUL;
                end
            end
            S_LAM: begin
                if (mul_stat.done) begin
                    n_lam   = mul_res;
                    n_state = S_LSQ;
                end
            end
            S_LSQ: begin
                if (mul_stat.done) begin
                    n_t     = mul_res;
                    n_state = S_X3A;
                end
            end
            S_X3A: begin
                n_tmp   = f_sub(r_t, r_ax, m_eff);
                n_state = S_X3B;
            end
            S_X3B: begin
                n_x3    = f_sub(r_tmp, r_bx, m_eff);
                n_state = S_YD;
            end
            S_YD: begin
                n_tmp   = f_sub(r_ax, r_x3, m_eff);
                n_state = S_YM;
            end
            S_YM: begin
                if (mul_stat.done) begin
                    n_t     = mul_res;
                    n_state = S_YS;
                end
            end
            S_YS: begin
                n_rx    = r_x3;
                n_ry    = f_sub(r_t, r_ay, m_eff);
                n_rinf  = 1'b0;
                n_state = S_ADD_DONE;
            end
            S_ADD_DONE: begin
                case (r_phase)
                    PH_ACC: begin
                        n_cx = r_rx;  n_cy = r_ry;  n_cinf = r_rinf;
                        n_state = S_SM_SHIFT;
                    end
                    PH_DBL: begin
                        n_dx = r_rx;  n_dy = r_ry;  n_dinf = r_rinf;
                        n_state = S_SM_TOP;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            // hold until the output register is free
            S_FIN: begin
                if (!r_ovalid || o_result.ready) begin
                    n_ovalid = 1'b1;
                    n_ox     = r_rinf ? '0 : r_rx;
                    n_oy     = r_rinf ? '0 : r_ry;
                    n_oinf   = r_rinf;
                    n_oflag  = r_flag;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_PAIR;
            r_pend    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_modulus <= MODULUS_RESET;
            r_curve_a <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg_we && i_cfg_idx == CFG_MODULUS) begin
                r_modulus <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_CURVE_A) begin
                r_curve_a <= i_cfg_data;
            end
        end
        r_cnt <= n_cnt;  r_kind <= n_kind;  r_k <= n_k;  r_flag <= n_flag;
        r_a <= n_a;  r_x1 <= n_x1;  r_y1 <= n_y1;  r_x2 <= n_x2;  r_y2 <= n_y2;
        r_inf1 <= n_inf1;  r_inf2 <= n_inf2;
        r_ax <= n_ax;  r_ay <= n_ay;  r_ainf <= n_ainf;
        r_bx <= n_bx;  r_by <= n_by;  r_binf <= n_binf;
        r_cx <= n_cx;  r_cy <= n_cy;  r_cinf <= n_cinf;
        r_dx <= n_dx;  r_dy <= n_dy;  r_dinf <= n_dinf;
        r_rx <= n_rx;  r_ry <= n_ry;  r_rinf <= n_rinf;
        r_num <= n_num;  r_den <= n_den;  r_inv <= n_inv;  r_pow <= n_pow;
        r_e <= n_e;  r_lam <= n_lam;  r_t <= n_t;  r_tmp <= n_tmp;  r_x3 <= n_x3;
        r_ox <= n_ox;  r_oy <= n_oy;  r_oinf <= n_oinf;  r_oflag <= n_oflag;
    end

    assign i_item.ready                = (r_state == S_IDLE);
    assign o_result.valid              = r_ovalid;
    assign o_result.result_x           = r_ox;
    assign o_result.result_y           = r_oy;
    assign o_result.result_at_infinity = r_oinf;
    assign o_result.zero_divisor       = r_oflag;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_stat.busy && !r_pend)
        else $error("product started while multiplier busy");

    a_done_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> r_pend)
        else $error("product finished with none outstanding");

    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> mul_res < m_eff)
        else $error("product not reduced below modulus");

    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oinf) |-> (r_ox == '0 && r_oy == '0))
        else $error("point at infinity with nonzero coordinates");

    a_accept_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == S_RED))
        else $error("accepted beat did not start reduction");

endmodule
